// File: src/arp_pkg.sv
// Shared types, character codes and matcher step functions for the AT response receiver.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package arp_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_IDLE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int OK_LEN  = 4;
    localparam int ERR_LEN = 7;

    localparam logic [7:0] OK_PATTERN [OK_LEN] = '{CH_O, CH_K, CH_CR, CH_LF};
    localparam logic [7:0] ERR_PATTERN [ERR_LEN] =
        '{CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR, CH_LF};

    typedef struct packed {
        logic       hit;
        logic [1:0] next_state;
    } ok_step_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] next_state;
    } err_step_t;

    // A wrong byte sends the matcher home; it is not retried as a new start.
    function automatic ok_step_t ok_advance(input logic [1:0] s, input logic [7:0] b);
        ok_step_t r;
        r.hit        = 1'b0;
        r.next_state = 2'd0;
        if (s == 2'(OK_LEN - 1))
        begin
            r.hit = (OK_PATTERN[s] == b);
        end
        else if (OK_PATTERN[s] == b)
        begin
            r.next_state = s + 2'd1;
        end
        return r;
    endfunction

    function automatic err_step_t err_advance(input logic [2:0] s, input logic [7:0] b);
        err_step_t r;
        r.hit        = 1'b0;
        r.next_state = 3'd0;
        priority if (s >= 3'(ERR_LEN))
        begin
            r.next_state = 3'd0;
        end
        else if (s == 3'(ERR_LEN - 1))
        begin
            r.hit = (ERR_PATTERN[s] == b);
        end
        else if (ERR_PATTERN[s] == b)
        begin
            r.next_state = s + 3'd1;
        end
        return r;
    endfunction

endpackage

// File: src/arp_line_store.sv
// Line store: single write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module arp_line_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/at_response_receiver.sv
// AT response receiver top level: matchers, flags, fill index and result register.
// Depends on arp_pkg and arp_line_store.
`timescale 1ns / 1ps

// Channel | Signals                                          | Direction
// --------+--------------------------------------------------+----------
// input   | in_valid, in_stall, operation, rx_byte, overrun, | in
//         | read_address                                     |
// result  | out_valid, out_stall, ok_seen, error_seen,       | out
//         | response_ready, unsolicited_ready, receive_error,|
//         | fill_count, read_data                            |
//
// One item per cycle while in_stall is low: each accepted item updates state and
// loads the result register at the same edge; its result shows in the next cycle.
// The line store read is the only registered memory access and sets that latency.
// Reset clears flags, matchers, fill index and result valid; the store is not cleared.
// A stalled result holds, and the input is stalled only while a result waits and
// out_stall is high, so the block keeps full rate whenever the sink takes results.

module at_response_receiver #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] rx_byte,
    input  logic       overrun,
    input  logic [8:0] read_address,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       ok_seen,
    output logic       error_seen,
    output logic       response_ready,
    output logic       unsolicited_ready,
    output logic       receive_error,
    output logic [9:0] fill_count,
    output logic [7:0] read_data
);

    import arp_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 9) ? CNT_W : 9;

    // State; the flags double as the result fields since they only move on accept.
    logic [1:0]       ok_state_reg,  ok_state_next;
    logic [2:0]       err_state_reg, err_state_next;
    logic             ok_flag_reg,   ok_flag_next;
    logic             err_flag_reg,  err_flag_next;
    logic             resp_flag_reg, resp_flag_next;
    logic             unsol_flag_reg, unsol_flag_next;
    logic             ovf_flag_reg,  ovf_flag_next;
    logic [CNT_W-1:0] wr_index_reg,  wr_index_next;

    // Result-only registers.
    logic             out_valid_reg, out_valid_next;
    logic             rx_err_reg,    rx_err_next;
    logic             rd_hit_reg,    rd_hit_next;

    logic             accept;
    op_t              op;
    ok_step_t         ok_step;
    err_step_t        err_step;
    logic             store_full;
    logic             wr_en;
    logic             rd_en;
    logic [CMP_W-1:0] addr_ext;
    logic [CMP_W-1:0] index_ext;
    logic [7:0]       rd_data;

    // Stall the source only while a finished result is held by the sink.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op       = op_t'(operation);

    assign ok_step    = ok_advance(ok_state_reg, rx_byte);
    assign err_step   = err_advance(err_state_reg, rx_byte);
    assign store_full = (wr_index_reg == CNT_W'(BUFFER_DEPTH));
    assign addr_ext   = CMP_W'(read_address);
    assign index_ext  = CMP_W'(wr_index_reg);

    always_comb
    begin
        ok_state_next   = ok_state_reg;
        err_state_next  = err_state_reg;
        ok_flag_next    = ok_flag_reg;
        err_flag_next   = err_flag_reg;
        resp_flag_next  = resp_flag_reg;
        unsol_flag_next = unsol_flag_reg;
        ovf_flag_next   = ovf_flag_reg;
        wr_index_next   = wr_index_reg;
        rx_err_next     = ovf_flag_reg;
        rd_hit_next     = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (op)
            OP_BYTE:
            begin
                // Advance both matchers even when the byte is dropped.
                ok_state_next  = ok_step.next_state;
                err_state_next = err_step.next_state;
                if (ok_step.hit)
                begin
                    ok_flag_next = 1'b1;
                end
                if (err_step.hit)
                begin
                    err_flag_next = 1'b1;
                end
                if (store_full)
                begin
                    ovf_flag_next = 1'b1;
                end
                else
                begin
                    wr_en         = accept;
                    wr_index_next = wr_index_reg + CNT_W'(1);
                end
                rx_err_next = ovf_flag_next;
            end
            OP_IDLE:
            begin
                // Report pending overflow or UART overrun, then drop the overflow.
                resp_flag_next  = 1'b1;
                unsol_flag_next = 1'b1;
                rx_err_next     = ovf_flag_reg || overrun;
                ovf_flag_next   = 1'b0;
            end
            OP_CLEAR:
            begin
                // Matcher states are kept across a clear.
                wr_index_next   = '0;
                ok_flag_next    = 1'b0;
                err_flag_next   = 1'b0;
                resp_flag_next  = 1'b0;
                unsol_flag_next = 1'b0;
                ovf_flag_next   = 1'b0;
                rx_err_next     = 1'b0;
            end
            OP_READ:
            begin
                // Positions at or past the fill index read as zero.
                rd_en       = accept;
                rd_hit_next = (addr_ext < index_ext);
            end
            default:
            begin
                rx_err_next = ovf_flag_reg;
            end
        endcase

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_state_reg   <= '0;
            err_state_reg  <= '0;
            ok_flag_reg    <= 1'b0;
            err_flag_reg   <= 1'b0;
            resp_flag_reg  <= 1'b0;
            unsol_flag_reg <= 1'b0;
            ovf_flag_reg   <= 1'b0;
            wr_index_reg   <= '0;
            out_valid_reg  <= 1'b0;
            rx_err_reg     <= 1'b0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                ok_state_reg   <= ok_state_next;
                err_state_reg  <= err_state_next;
                ok_flag_reg    <= ok_flag_next;
                err_flag_reg   <= err_flag_next;
                resp_flag_reg  <= resp_flag_next;
                unsol_flag_reg <= unsol_flag_next;
                ovf_flag_reg   <= ovf_flag_next;
                wr_index_reg   <= wr_index_next;
                rx_err_reg     <= rx_err_next;
                rd_hit_reg     <= rd_hit_next;
            end
        end
    end

    arp_line_store #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_index_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (addr_ext[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign out_valid         = out_valid_reg;
    assign ok_seen           = ok_flag_reg;
    assign error_seen        = err_flag_reg;
    assign response_ready    = resp_flag_reg;
    assign unsolicited_ready = unsol_flag_reg;
    assign receive_error     = rx_err_reg;
    // Fit the fill index to the 10-bit field; it truncates for store depths above 1023.
    assign fill_count        = 10'(wr_index_reg);
    assign read_data         = rd_hit_reg ? rd_data : 8'd0;

endmodule

// File: src/arp_checker.sv
// Port-level checks for the AT response receiver, bound to the top level.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_stall,
    input logic       ok_seen,
    input logic       error_seen,
    input logic       response_ready,
    input logic       unsolicited_ready,
    input logic       receive_error,
    input logic [9:0] fill_count
);

    import arp_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A clear leaves every flag down and the store empty.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (operation == OP_CLEAR) |=>
            out_valid && (fill_count == 10'd0) && !ok_seen && !error_seen &&
            !response_ready && !unsolicited_ready && !receive_error)
        else $error("clear did not empty the receiver");

    // An idle event raises both ready flags.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (operation == OP_IDLE) |=>
            out_valid && response_ready && unsolicited_ready)
        else $error("idle did not raise ready flags");

    // A byte either lands in the store or is reported as an error.
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (operation == OP_BYTE) |=>
            (fill_count == $past(fill_count) + 10'd1) || receive_error)
        else $error("byte neither stored nor flagged");

endmodule

bind at_response_receiver arp_checker u_arp_checker (.*);
